/* hw/rtl/vn_pkg.sv */
// Shared constants for the vector normalize pipeline.
package vn_pkg;

    // Default component width (Q15.16 at 32 bits)
    localparam int COMP_WIDTH_DEFAULT = 32;

    // Result format: signed Q1.30
    localparam int UNIT_WIDTH = 32;
    localparam int UNIT_FRAC  = 30;

    // Quotient bits, bit UNIT_FRAC down to bit 0
    localparam int QUOT_WIDTH = UNIT_FRAC + 1;

    // Pipeline depth ahead of the square root: abs, partial products,
    // per-component squares, sum of squares
    localparam int SQUARE_STAGES = 4;

endpackage

/* hw/rtl/vn_square.sv */
// Absolute values, split squaring and sum of squares over four stages.
module vn_square
    import vn_pkg::*;
#(
    parameter int W = COMP_WIDTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [W-1:0]     in_x,
    input  logic [W-1:0]     in_y,
    input  logic [W-1:0]     in_z,
    output logic             out_valid,
    output logic [2*W:0]     out_sum,
    output logic             out_zero,
    output logic [3*W-1:0]   out_mag,
    output logic [2:0]       out_neg
);

    localparam int H  = W / 2;
    localparam int HW = W - H;
    localparam int SW = 2 * W + 1;

    logic [W-1:0]    comp [3];
    logic [W-1:0]    abs_reg [3];
    logic [2:0]      neg_reg;
    logic            v1_reg;

    logic [2*HW-1:0]  ph_reg [3];
    logic [HW+H-1:0]  pm_reg [3];
    logic [2*H-1:0]   pl_reg [3];
    logic [W-1:0]     abs2_reg [3];
    logic [2:0]       neg2_reg;
    logic             v2_reg;

    logic [2*W-1:0]   sq_reg [3];
    logic [W-1:0]     abs3_reg [3];
    logic [2:0]       neg3_reg;
    logic             v3_reg;

    logic [SW-1:0]    sum_next;
    logic [SW-1:0]    sum_reg;
    logic [W-1:0]     abs4_reg [3];
    logic [2:0]       neg4_reg;
    logic             v4_reg;

    assign comp[0] = in_x;
    assign comp[1] = in_y;
    assign comp[2] = in_z;

    // Advance valid bits; the pipeline never stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Per-component datapath: abs, partial products, square
    for (genvar c = 0; c < 3; c++)
    begin : g_comp
        always_ff @(posedge clk)
        begin
            neg_reg[c]  <= comp[c][W-1];
            abs_reg[c]  <= comp[c][W-1] ? (~comp[c] + W'(1)) : comp[c];

            ph_reg[c]   <= (2*HW)'(abs_reg[c][W-1:H]) * (2*HW)'(abs_reg[c][W-1:H]);
            pm_reg[c]   <= (HW+H)'(abs_reg[c][W-1:H]) * (HW+H)'(abs_reg[c][H-1:0]);
            pl_reg[c]   <= (2*H)'(abs_reg[c][H-1:0]) * (2*H)'(abs_reg[c][H-1:0]);
            abs2_reg[c] <= abs_reg[c];
            neg2_reg[c] <= neg_reg[c];

            sq_reg[c]   <= ((2*W)'(ph_reg[c]) << (2*H))
                         + ((2*W)'(pm_reg[c]) << (H+1))
                         + (2*W)'(pl_reg[c]);
            abs3_reg[c] <= abs2_reg[c];
            neg3_reg[c] <= neg2_reg[c];

            abs4_reg[c] <= abs3_reg[c];
            neg4_reg[c] <= neg3_reg[c];
        end
    end

    // Sum the three squares
    assign sum_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign out_valid = v4_reg;
    assign out_sum   = sum_reg;
    assign out_zero  = (sum_reg == '0);
    assign out_mag   = {abs4_reg[2], abs4_reg[1], abs4_reg[0]};
    assign out_neg   = neg4_reg;

endmodule

/* hw/rtl/vn_sqrt.sv */
// Integer square root, one root bit per pipeline stage.
module vn_sqrt
    import vn_pkg::*;
#(
    parameter int W      = COMP_WIDTH_DEFAULT,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [2*W:0]      in_sum,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [W-1:0]      out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int SW = 2 * W + 1;
    localparam int TW = SW + 2;

    // Index i holds the input of stage i; index W holds the final result
    logic [SW-1:0]     rem_reg  [W+1];
    logic [W-1:0]      root_reg [W+1];
    logic [SIDE_W-1:0] side_reg [W+1];
    logic [W:0]        vld_reg;

    assign rem_reg[0]  = in_sum;
    assign root_reg[0] = '0;
    assign side_reg[0] = in_side;
    assign vld_reg[0]  = in_valid;

    for (genvar i = 0; i < W; i++)
    begin : g_stage
        localparam int B = W - 1 - i;
        logic [TW-1:0] trial;
        logic          take;

        // Try setting root bit B: (r + 2^B)^2 - r^2 against the remainder
        assign trial = (TW'(root_reg[i]) << (B + 1)) + (TW'(1) << (2 * B));
        assign take  = (TW'(rem_reg[i]) >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1]  <= take ? SW'(TW'(rem_reg[i]) - trial) : rem_reg[i];
            root_reg[i+1] <= root_reg[i] | (W'(take) << B);
            side_reg[i+1] <= side_reg[i];
        end
    end

    assign out_valid = vld_reg[W];
    assign out_root  = root_reg[W];
    assign out_side  = side_reg[W];

endmodule

/* hw/rtl/vn_div.sv */
// Three-lane restoring divider, one quotient bit per stage, plus sign and zero fixup.
module vn_div
    import vn_pkg::*;
#(
    parameter int W = COMP_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [W-1:0]          in_root,
    input  logic [3*W-1:0]        in_mag,
    input  logic [2:0]            in_neg,
    input  logic                  in_zero,
    output logic                  out_valid,
    output logic [UNIT_WIDTH-1:0] out_x,
    output logic [UNIT_WIDTH-1:0] out_y,
    output logic [UNIT_WIDTH-1:0] out_z,
    output logic                  out_zero
);

    localparam int RW = W + 1;

    logic [W-1:0]          root_reg [QUOT_WIDTH+1];
    logic [2:0]            neg_reg  [QUOT_WIDTH+1];
    logic [QUOT_WIDTH:0]   zero_reg;
    logic [QUOT_WIDTH:0]   vld_reg;
    logic [RW-1:0]         rem_reg  [3][QUOT_WIDTH+1];
    logic [QUOT_WIDTH-1:0] quot_reg [3][QUOT_WIDTH+1];

    logic [UNIT_WIDTH-1:0] unit_next [3];
    logic [UNIT_WIDTH-1:0] unit_reg  [3];
    logic                  zero_out_reg;
    logic                  vld_out_reg;

    assign root_reg[0] = in_root;
    assign neg_reg[0]  = in_neg;
    assign zero_reg[0] = in_zero;
    assign vld_reg[0]  = in_valid;

    for (genvar k = 0; k < QUOT_WIDTH; k++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            root_reg[k+1] <= root_reg[k];
            neg_reg[k+1]  <= neg_reg[k];
            zero_reg[k+1] <= zero_reg[k];
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        assign rem_reg[c][0]  = RW'(in_mag[c*W +: W]);
        assign quot_reg[c][0] = '0;

        for (genvar k = 0; k < QUOT_WIDTH; k++)
        begin : g_step
            localparam int Q = QUOT_WIDTH - 1 - k;
            logic          take;
            logic [RW-1:0] diff;

            // Subtract the magnitude when it fits, then shift in a zero
            assign take = (rem_reg[c][k] >= RW'(root_reg[k]));
            assign diff = take ? (rem_reg[c][k] - RW'(root_reg[k])) : rem_reg[c][k];

            always_ff @(posedge clk)
            begin
                rem_reg[c][k+1]  <= diff << 1;
                quot_reg[c][k+1] <= quot_reg[c][k] | (QUOT_WIDTH'(take) << Q);
            end
        end

        // Apply sign; drop the quotient of a zero vector
        always_comb
        begin
            if (zero_reg[QUOT_WIDTH])
            begin
                unit_next[c] = '0;
            end
            else if (neg_reg[QUOT_WIDTH][c])
            begin
                unit_next[c] = UNIT_WIDTH'(0) - UNIT_WIDTH'(quot_reg[c][QUOT_WIDTH]);
            end
            else
            begin
                unit_next[c] = UNIT_WIDTH'(quot_reg[c][QUOT_WIDTH]);
            end
        end

        always_ff @(posedge clk)
        begin
            unit_reg[c] <= unit_next[c];
        end
    end

    // Hold the result for its single strobe cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_out_reg <= 1'b0;
        end
        else
        begin
            vld_out_reg <= vld_reg[QUOT_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        zero_out_reg <= zero_reg[QUOT_WIDTH];
    end

    assign out_valid = vld_out_reg;
    assign out_x     = unit_reg[0];
    assign out_y     = unit_reg[1];
    assign out_z     = unit_reg[2];
    assign out_zero  = zero_out_reg;

endmodule

/* hw/rtl/vector3_normalize.sv */
// Top level of the three-component vector normalizer.
//
// Takes one vector per clock and returns one unit vector per vector, in order:
// four stages form the exact sum of squares, COMPONENT_WIDTH stages take the
// square root one bit each, 31 stages divide each component by the magnitude
// one quotient bit each, and one stage registers the result. busy stays low,
// so start may be held high every cycle; done marks each result for one cycle
// and the receiver must take it then. A zero vector returns zero components
// with was_zero set.
module vector3_normalize
    import vn_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMP_WIDTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [COMPONENT_WIDTH-1:0] in_x,
    input  logic [COMPONENT_WIDTH-1:0] in_y,
    input  logic [COMPONENT_WIDTH-1:0] in_z,
    output logic                       done,
    output logic [UNIT_WIDTH-1:0]      unit_x,
    output logic [UNIT_WIDTH-1:0]      unit_y,
    output logic [UNIT_WIDTH-1:0]      unit_z,
    output logic                       was_zero
);

    localparam int W      = COMPONENT_WIDTH;
    localparam int SIDE_W = 3 * W + 4;

    logic              sq_valid;
    logic [2*W:0]      sq_sum;
    logic              sq_zero;
    logic [3*W-1:0]    sq_mag;
    logic [2:0]        sq_neg;

    logic              rt_valid;
    logic [W-1:0]      rt_root;
    logic [SIDE_W-1:0] rt_side;

    // Pipeline always advances
    assign busy = 1'b0;

    vn_square #(.W(W)) u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .out_valid (sq_valid),
        .out_sum   (sq_sum),
        .out_zero  (sq_zero),
        .out_mag   (sq_mag),
        .out_neg   (sq_neg)
    );

    vn_sqrt #(.W(W), .SIDE_W(SIDE_W)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_sum    (sq_sum),
        .in_side   ({sq_zero, sq_neg, sq_mag}),
        .out_valid (rt_valid),
        .out_root  (rt_root),
        .out_side  (rt_side)
    );

    vn_div #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .in_root   (rt_root),
        .in_mag    (rt_side[3*W-1:0]),
        .in_neg    (rt_side[3*W+2:3*W]),
        .in_zero   (rt_side[3*W+3]),
        .out_valid (done),
        .out_x     (unit_x),
        .out_y     (unit_y),
        .out_z     (unit_z),
        .out_zero  (was_zero)
    );

endmodule

/* hw/rtl/vn_checker.sv */
// Port-level assertions for the vector normalizer, bound to the top level.
module vn_assert
    import vn_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMP_WIDTH_DEFAULT
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [UNIT_WIDTH-1:0] unit_x,
    input logic [UNIT_WIDTH-1:0] unit_y,
    input logic [UNIT_WIDTH-1:0] unit_z,
    input logic                  was_zero
);

    localparam int LATENCY = SQUARE_STAGES + COMPONENT_WIDTH + QUOT_WIDTH + 1;
    localparam logic signed [UNIT_WIDTH-1:0] UNIT_ONE = UNIT_WIDTH'(1) << UNIT_FRAC;

    // Never refuse a transaction
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every accepted transaction returns after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(start && !busy && rst_n, LATENCY) |-> done)
        else $error("result missing at expected latency");

    // A zero vector yields all-zero components
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (done && was_zero) |-> (unit_x == '0 && unit_y == '0 && unit_z == '0))
        else $error("zero vector gave nonzero result");

    // Components stay within plus or minus one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($signed(unit_x) <= UNIT_ONE && $signed(unit_x) >= -UNIT_ONE
               && $signed(unit_y) <= UNIT_ONE && $signed(unit_y) >= -UNIT_ONE
               && $signed(unit_z) <= UNIT_ONE && $signed(unit_z) >= -UNIT_ONE))
        else $error("unit component out of range");

endmodule

bind vector3_normalize vn_assert #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_vn_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .unit_x   (unit_x),
    .unit_y   (unit_y),
    .unit_z   (unit_z),
    .was_zero (was_zero)
);

/* tb/sv/vn_checker.sv */
`timescale 1ns / 100ps
// Checker for the vector normalizer: predicts unit vectors and compares results.
module vn_checker
    import vn_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMP_WIDTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [COMPONENT_WIDTH-1:0] in_x,
    input  logic [COMPONENT_WIDTH-1:0] in_y,
    input  logic [COMPONENT_WIDTH-1:0] in_z,
    input  logic                       done,
    input  logic [UNIT_WIDTH-1:0]      unit_x,
    input  logic [UNIT_WIDTH-1:0]      unit_y,
    input  logic [UNIT_WIDTH-1:0]      unit_z,
    input  logic                       was_zero,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic [UNIT_WIDTH-1:0] ux;
        logic [UNIT_WIDTH-1:0] uy;
        logic [UNIT_WIDTH-1:0] uz;
        logic                  zero;
    } unit_vec_t;

    unit_vec_t expected_units[$];

    // Magnitude of a signed component
    function automatic logic [63:0] comp_mag(logic [COMPONENT_WIDTH-1:0] c);
        logic [63:0] v;
        v = 64'(c);
        if (c[COMPONENT_WIDTH-1])
            v = 64'(-c) & ((64'd1 << COMPONENT_WIDTH) - 1);
        return v;
    endfunction

    // Compute the expected normalized vector
    function automatic unit_vec_t normalize(logic [COMPONENT_WIDTH-1:0] x,
                                            logic [COMPONENT_WIDTH-1:0] y,
                                            logic [COMPONENT_WIDTH-1:0] z);
        logic [63:0]  m [3];
        logic         neg [3];
        logic [127:0] sum_sq;
        logic [63:0]  root;
        logic [63:0]  cand;
        logic [127:0] num;
        logic [63:0]  q;
        logic [UNIT_WIDTH-1:0] res [3];
        unit_vec_t r;
        m[0] = comp_mag(x); neg[0] = x[COMPONENT_WIDTH-1];
        m[1] = comp_mag(y); neg[1] = y[COMPONENT_WIDTH-1];
        m[2] = comp_mag(z); neg[2] = z[COMPONENT_WIDTH-1];
        sum_sq = 128'(m[0]) * m[0] + 128'(m[1]) * m[1] + 128'(m[2]) * m[2];
        if (sum_sq == 0)
        begin
            r = '{ux: '0, uy: '0, uz: '0, zero: 1'b1};
            return r;
        end
        // Square root, floor, one bit at a time
        root = 0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if (128'(cand) * cand <= sum_sq)
                root = cand;
        end
        for (int i = 0; i < 3; i++)
        begin
            num = 128'(m[i]) << UNIT_FRAC;
            q = num / root;
            res[i] = neg[i] ? UNIT_WIDTH'(-q) : UNIT_WIDTH'(q);
        end
        r = '{ux: res[0], uy: res[1], uz: res[2], zero: 1'b0};
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
    end

    assign pending = expected_units.size();

    // Check each result, then record each accepted transaction
    always @(posedge clk)
    begin
        unit_vec_t e;
        if (rst_n && done)
        begin
            if (expected_units.size() == 0)
            begin
                $display("%0t: result with no transaction outstanding", $time);
                fail_count++;
            end
            else
            begin
                e = expected_units.pop_front();
                if (unit_x !== e.ux) report_mismatch("unit_x", unit_x, e.ux);
                if (unit_y !== e.uy) report_mismatch("unit_y", unit_y, e.uy);
                if (unit_z !== e.uz) report_mismatch("unit_z", unit_z, e.uz);
                if (was_zero !== e.zero) report_mismatch("was_zero", 32'(was_zero), 32'(e.zero));
            end
        end
        if (rst_n && start && !busy)
            expected_units.push_back(normalize(in_x, in_y, in_z));
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Top of the vector normalizer testbench: stimulus and verdict.
module testbench;
    import vn_pkg::*;

    localparam int CW      = COMP_WIDTH_DEFAULT;
    localparam int LATENCY = CW + 36;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic [CW-1:0] in_x, in_y, in_z;
    logic          done;
    logic [UNIT_WIDTH-1:0] unit_x, unit_y, unit_z;
    logic          was_zero;
    int            fail_count;
    int            pending;

    vector3_normalize #(.COMPONENT_WIDTH(CW)) i_dut (.*);

    vn_checker #(.COMPONENT_WIDTH(CW)) i_checker (.*);

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    // Random component, often near the extremes or small
    function automatic logic [CW-1:0] rand_comp();
        unique case ($urandom_range(0, 5))
            0: return CW'($urandom_range(0, 3)) - CW'(1);
            1: return {1'b1, {(CW-1){1'b0}}} + CW'($urandom_range(0, 2));
            2: return {1'b0, {(CW-1){1'b1}}} - CW'($urandom_range(0, 2));
            3: return CW'($urandom) >>> $urandom_range(0, CW-1);
            4: return '0;
            default: return CW'($urandom);
        endcase
    endfunction

    // Hold one vector until accepted
    task automatic send_vector(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        start <= 1'b1;
        in_x <= x; in_y <= y; in_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    localparam logic [CW-1:0] MAX_C = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MIN_C = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] ZERO_C = '0;
    localparam logic [CW-1:0] ONE_C  = CW'(1);
    localparam logic [CW-1:0] NEG1_C = '1;

    initial
    begin
        int burst;
        int wait_cycles;
        logic [CW-1:0] d [14][3];
        start = 1'b0; in_x = '0; in_y = '0; in_z = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // Directed: zero vector, axes, extremes, mixed signs
        d = '{'{ZERO_C, ZERO_C, ZERO_C}, '{ONE_C, ZERO_C, ZERO_C},
              '{ZERO_C, NEG1_C, ZERO_C}, '{ZERO_C, ZERO_C, MIN_C},
              '{MAX_C, ZERO_C, ZERO_C}, '{MIN_C, MIN_C, MIN_C}, '{MAX_C, MAX_C, MAX_C},
              '{MAX_C, MIN_C, MAX_C}, '{ONE_C, ONE_C, ONE_C}, '{NEG1_C, NEG1_C, NEG1_C},
              '{CW'(3), CW'(-4), ZERO_C}, '{CW'(32'h0001_0000), ZERO_C, CW'(32'hFFFF_0000)},
              '{MIN_C, ONE_C, ZERO_C},
              '{CW'(32'hAAAA_AAAA), CW'(32'h5555_5555), CW'(32'hFFFF_FFFF)}};
        foreach (d[i])
            send_vector(d[i][0], d[i][1], d[i][2]);
        // Random bursts with gaps
        for (int n = 0; n < 950;)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++, n++)
                send_vector(rand_comp(), rand_comp(), rand_comp());
            start <= 1'b0;
            wait_cycles = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            repeat (wait_cycles) @(negedge clk);
        end
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
